>>> hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// shared types and constants of the multi stack engine
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SIDX_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 5;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned NUM_CAP   = 4;

  localparam logic [ACT_W-1:0] ACT_RESET = 3'd4;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STACKS_IN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_THREE = 3'd4;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_INVALID  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic [SIDX_W-1:0]         stack_index;
    logic signed [DATA_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/multi_stack_engine_unit.sv
// ----------------------------------------------------------------------------
// multi_stack_engine_unit
// several lifo stacks kept in one shared entry memory
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------
// in_      | input     | in_valid / in_stall | op, stack_index, push_value
// out_     | output    | out_valid/out_stall | status, data, last
// cfg_     | input     | cfg_valid/cfg_ready | register index, write data
//
// with no stalls push and errors are done in the execute state; pop, peek and
// display also pass through the read state, fed by the registered memory read
// the result register loads from the execute state for push and errors and from
// the read state for pop, peek and display, one entry per cycle while out_stall is low
// rst_n (synchronous) clears fill counts and control state and loads the configuration reset values
// a stalled result holds the engine; a display resumes where it stopped
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_engine_unit #(
  parameter int unsigned NUM_STACKS  = 4,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mse_pkg::in_item_t             in_data,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mse_pkg::out_item_t                 out_data,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mse_pkg::CFG_DAT_W-1:0] cfg_data
);

  import mse_pkg::*;

  // widths that follow from the parameters
  localparam int unsigned SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned PW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = SW + PW;
  localparam int unsigned MEMD = 2 ** AW;
  localparam int unsigned CMPW = (FW > CAP_W) ? FW : CAP_W;
  localparam int unsigned NSW  = 5;

  // --------------------------------------------------------------------------
  // configuration registers, always ready: writes must arrive only while idle, which the block does not enforce
  // --------------------------------------------------------------------------
  logic [ACT_W-1:0] stacks_in_use_r;
  logic [CAP_W-1:0] capacity_r [NUM_CAP];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_in_use_r <= ACT_RESET;
      for (int i = 0; i < NUM_CAP; i++) begin
        capacity_r[i] <= CAP_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STACKS_IN_USE:  stacks_in_use_r <= cfg_data[ACT_W-1:0];
        REG_CAPACITY_ZERO:  capacity_r[0]   <= cfg_data;
        REG_CAPACITY_ONE:   capacity_r[1]   <= cfg_data;
        REG_CAPACITY_TWO:   capacity_r[2]   <= cfg_data;
        REG_CAPACITY_THREE: capacity_r[3]   <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  in_item_t          cmd_r;                 // item under work
  logic [PW-1:0]     pos_r, pos_nxt;        // display: position being read
  logic [FW-1:0]     fill_r [NUM_STACKS];   // entries held per stack
  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;
  logic [DATA_W-1:0] mem [MEMD];
  logic [DATA_W-1:0] mem_rd_r;

  // control from the sequencer
  logic              out_load;
  logic              fill_we;
  logic [FW-1:0]     fill_wdata;
  logic              mem_we;
  logic              mem_re;
  logic [PW-1:0]     mem_wpos;
  logic [PW-1:0]     mem_rpos;

  // decode of the held item
  logic [SW-1:0]     sidx;
  logic [NSW-1:0]    act_eff;
  logic              idx_ok;
  logic [FW-1:0]     fill_cur;
  logic [CAP_W-1:0]  cap_raw;
  logic [CMPW-1:0]   cap_eff;
  logic              out_free;

  assign sidx     = SW'(cmd_r.stack_index);
  assign fill_cur = fill_r[sidx];
  assign cap_raw  = capacity_r[cmd_r.stack_index];
  assign out_free = !out_valid_r || !out_stall;

  // stack count clamped to 1..NUM_STACKS, capacity to 1..STACK_DEPTH
  always_comb begin
    if (stacks_in_use_r == '0) begin
      act_eff = NSW'(1);
    end else if (NSW'(stacks_in_use_r) > NSW'(NUM_STACKS)) begin
      act_eff = NSW'(NUM_STACKS);
    end else begin
      act_eff = NSW'(stacks_in_use_r);
    end
    if (cap_raw == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap_raw) > CMPW'(STACK_DEPTH)) begin
      cap_eff = CMPW'(STACK_DEPTH);
    end else begin
      cap_eff = CMPW'(cap_raw);
    end
  end

  assign idx_ok = NSW'(cmd_r.stack_index) < act_eff;

  // --------------------------------------------------------------------------
  // sequencer: latch item, execute against fill count, then for pop, peek and display stream reads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    out_load     = 1'b0;
    out_item_nxt = '{status: STAT_OK, data: '0, last: 1'b1};
    fill_we      = 1'b0;
    fill_wdata   = fill_cur;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wpos     = PW'(fill_cur);
    mem_rpos     = PW'(fill_cur - FW'(1));
    pos_nxt      = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!idx_ok) begin
          out_item_nxt.status = STAT_INVALID;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          case (cmd_r.op)
            OP_PUSH: begin
              if (CMPW'(fill_cur) >= cap_eff) begin
                out_item_nxt.status = STAT_OVERFLOW;
              end else begin
                out_item_nxt.data = cmd_r.push_value;
              end
              if (out_free) begin
                out_load  = 1'b1;
                state_nxt = ST_IDLE;
                if (out_item_nxt.status == STAT_OK) begin
                  mem_we     = 1'b1;
                  fill_we    = 1'b1;
                  fill_wdata = fill_cur + FW'(1);
                end
              end
            end
            default: begin
              // pop, peek and display all start at the top entry
              if (fill_cur == '0) begin
                out_item_nxt.status = STAT_EMPTY;
                if (out_free) begin
                  out_load  = 1'b1;
                  state_nxt = ST_IDLE;
                end
              end else begin
                mem_re    = 1'b1;
                pos_nxt   = mem_rpos;
                state_nxt = ST_READ;
                if (cmd_r.op == OP_POP) begin
                  fill_we    = 1'b1;
                  fill_wdata = fill_cur - FW'(1);
                end
              end
            end
          endcase
        end
      end
      ST_READ: begin
        out_item_nxt.data = mem_rd_r;
        out_item_nxt.last = (cmd_r.op != OP_DISPLAY) || (pos_r == '0);
        mem_rpos          = pos_r - PW'(1);
        if (out_free) begin
          out_load = 1'b1;
          if (out_item_nxt.last) begin
            state_nxt = ST_IDLE;
          end else begin
            // next entry down, data lands while this result is taken
            mem_re  = 1'b1;
            pos_nxt = mem_rpos;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // item latch and display position
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_data;
    end
    pos_r <= pos_nxt;
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (fill_we) begin
      fill_r[sidx] <= fill_wdata;
    end
  end

  // entry memory: stack number in the high address bits, position below
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{sidx, mem_wpos}] <= cmd_r.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rd_r <= mem[{sidx, mem_rpos}];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && idx_ok) |-> (CMPW'(fill_cur) <= CMPW'(STACK_DEPTH)))
    else $error("fill count beyond stack depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register loaded while a result still waits");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("transfer taken outside idle");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && fill_we) |=> (fill_r[$past(sidx)] == $past(fill_cur) + FW'(1)))
    else $error("push did not advance the fill count");

endmodule

`default_nettype wire
